>>> hdl/stuck_sensor_detector_macros.svh
// Assertion macros used by the checker file ssd_checker.sv.
`ifndef STUCK_SENSOR_DETECTOR_MACROS_SVH
`define STUCK_SENSOR_DETECTOR_MACROS_SVH

// Flag a property that must hold at every clock edge out of reset.
`define SSD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ssd assertion failed");

// Flag a consequence that must hold in the cycle after its trigger.
`define SSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ssd assertion failed");

`endif

>>> hdl/ssd_pkg.sv
package ssd_pkg;

	localparam int THR_W     = 4;
	localparam int AXIS_IN_W = 16;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;

	localparam logic [THR_W-1:0] THR_RESET = 4'd7;

	// Register index taken from paddr[2]
	localparam logic REG_EQUAL_THRESHOLD = 1'b0;

	typedef struct packed {
		logic push;
		logic ready;
	} hist_ctrl_t;

endpackage

>>> hdl/ssd_cfg.sv
module ssd_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssd_pkg::APB_AW-1:0]  paddr,
	input  logic [ssd_pkg::APB_DW-1:0]  pwdata,
	output logic [ssd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [ssd_pkg::THR_W-1:0]   equal_threshold
);
	import ssd_pkg::*;

	logic                wr_en;
	logic                reg_sel;
	logic [THR_W-1:0]    thr_q;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_EQUAL_THRESHOLD);
	assign wr_en   = psel & penable & pwrite & pready & reg_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (wr_en) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = APB_DW'(thr_q);
		end
	end

	assign equal_threshold = thr_q;

endmodule

>>> hdl/ssd_history.sv
module ssd_history #(
	parameter int HISTORY_DEPTH = 8,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  ssd_pkg::hist_ctrl_t                        ctrl,
	input  logic signed [ssd_pkg::AXIS_IN_W-1:0]       accel_x,
	input  logic signed [ssd_pkg::AXIS_IN_W-1:0]       accel_y,
	input  logic signed [ssd_pkg::AXIS_IN_W-1:0]       accel_z,
	output logic [HISTORY_DEPTH-1:0][3*SAMPLE_BITS-1:0] rows
);
	import ssd_pkg::*;

	localparam int ROW_W = 3 * SAMPLE_BITS;

	logic [HISTORY_DEPTH-1:0][ROW_W-1:0] hist_q;
	logic [ROW_W-1:0]                    front;

	always_comb begin
		if (ctrl.ready) begin
			front = {SAMPLE_BITS'(accel_z), SAMPLE_BITS'(accel_y), SAMPLE_BITS'(accel_x)};
		end else begin
			front = hist_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= {SAMPLE_BITS'(i + 2), SAMPLE_BITS'(i + 1), SAMPLE_BITS'(i)};
			end
		end else if (ctrl.push) begin
			for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
				hist_q[i] <= hist_q[i-1];
			end
			hist_q[0] <= front;
		end
	end

	assign rows = hist_q;

endmodule

>>> hdl/ssd_match.sv
module ssd_match #(
	parameter int HISTORY_DEPTH = 8,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic [HISTORY_DEPTH-1:0][3*SAMPLE_BITS-1:0] rows,
	input  logic [ssd_pkg::THR_W-1:0]                  equal_threshold,
	output logic                                       stuck
);
	import ssd_pkg::*;

	localparam int CNT_W = $clog2(HISTORY_DEPTH);
	localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

	logic [HISTORY_DEPTH-1:0][HISTORY_DEPTH-1:0] eq;
	logic [HISTORY_DEPTH-1:0][CNT_W-1:0]         cnt;
	logic [HISTORY_DEPTH-1:0]                    hit;

	always_comb begin
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			for (int j = 0; j < HISTORY_DEPTH; j++) begin
				eq[i][j] = (i != j) && (rows[i] == rows[j]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			cnt[i] = '0;
			for (int j = 0; j < HISTORY_DEPTH; j++) begin
				cnt[i] = cnt[i] + CNT_W'(eq[i][j]);
			end
			hit[i] = CMP_W'(cnt[i]) >= CMP_W'(equal_threshold);
		end
	end

	assign stuck = |hit;

endmodule

>>> hdl/stuck_sensor_detector.sv
// Stuck accelerometer detector. Each request on the s_axis side is one sensor
// poll; each poll yields one result on the m_axis side, passed through valid_s1
// and the output register after acceptance. A poll is taken every cycle while
// the output does not stall: the history shifts at acceptance, and the pairwise
// compare of all history rows against each other plus the per-row match count
// runs from the history registers into the result register. The output register
// decouples the two sides, so one more poll is accepted while a result waits. The
// user must write the equal_threshold register (byte address 0, reset 7) over APB
// only while the block is idle; the block does not enforce this. A threshold of
// zero reports every poll inactive, and one above HISTORY_DEPTH-1 is never reached.
module stuck_sensor_detector #(
	parameter int HISTORY_DEPTH = 8,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [47:0]                 s_axis_tdata,  // accel_x, accel_y, accel_z
	input  logic [1:0]                  s_axis_tuser,  // accel_ready, gyro_ready
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,  // sensor_active, zero fill
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssd_pkg::APB_AW-1:0]  paddr,
	input  logic [ssd_pkg::APB_DW-1:0]  pwdata,
	output logic [ssd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import ssd_pkg::*;

	logic                                 s_acc;
	logic                                 adv_out;
	logic                                 valid_s1;
	logic                                 ready_s1;
	logic                                 m_valid_q;
	logic                                 active_q;
	logic                                 stuck;
	logic [THR_W-1:0]                     equal_threshold;
	logic [HISTORY_DEPTH-1:0][3*SAMPLE_BITS-1:0] rows;
	hist_ctrl_t                           hctrl;
	logic signed [AXIS_IN_W-1:0]          accel_x;
	logic signed [AXIS_IN_W-1:0]          accel_y;
	logic signed [AXIS_IN_W-1:0]          accel_z;

	assign accel_x = s_axis_tdata[15:0];
	assign accel_y = s_axis_tdata[31:16];
	assign accel_z = s_axis_tdata[47:32];

	assign adv_out       = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_out;
	assign s_acc         = s_axis_tvalid & s_axis_tready;

	assign hctrl.push  = s_acc;
	assign hctrl.ready = s_axis_tuser[0] & s_axis_tuser[1];

	ssd_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.equal_threshold (equal_threshold)
	);

	ssd_history #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_history (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (hctrl),
		.accel_x (accel_x),
		.accel_y (accel_y),
		.accel_z (accel_z),
		.rows    (rows)
	);

	ssd_match #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_match (
		.rows            (rows),
		.equal_threshold (equal_threshold),
		.stuck           (stuck)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_out) begin
				m_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			ready_s1 <= hctrl.ready;
		end
		if (adv_out && valid_s1) begin
			active_q <= ready_s1 & !stuck;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0, active_q};

endmodule

>>> hdl/ssd_checker.sv
`include "stuck_sensor_detector_macros.svh"

module ssd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	`SSD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	`SSD_ASSERT(a_in_open, clk, arst_n, m_axis_tvalid || s_axis_tready)

	`SSD_ASSERT_NEXT(a_thr_readback, clk, arst_n, psel && penable && pwrite && !paddr[2], !(psel && !pwrite && !paddr[2]) || (prdata[3:0] == $past(pwdata[3:0])))

endmodule

bind stuck_sensor_detector ssd_checker u_ssd_checker (.*);
